// ===== rtl/bma_pkg.sv =====
package bma_pkg;

    // order values (block size exponents) fit in five bits
    typedef logic [4:0] t_order;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_NOMEM = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [1:0] CFG_POOL_ORDER = 2'd1;
    localparam logic [1:0] CFG_HEADER     = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_START,
        S_A_SCAN,
        S_A_CHECK,
        S_A_TAKE,
        S_A_SPLIT,
        S_A_MARK,
        S_F_SUB1,
        S_F_SUB2,
        S_F_CHK,
        S_F_SLOT,
        S_F_PROBE,
        S_F_BUDDY,
        S_F_SET,
        S_RESP
    } t_state;

    // smallest order whose block holds need bytes, never below lo
    function automatic t_order need_order(input logic [16:0] need, input t_order lo);
        t_order r;
        r = 5'd17;
        for (int j = 16; j >= 0; j--) begin
            if ((17'(1) << j) >= need) r = 5'(j);
        end
        if (r < lo) r = lo;
        return r;
    endfunction

endpackage

// ===== rtl/bma_req_if.sv =====
interface bma_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] request_bytes;
    logic [31:0] free_address;

    modport source (output valid, output opcode, output request_bytes,
                    output free_address, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input free_address, output ready);
endinterface

// ===== rtl/bma_rsp_if.sv =====
interface bma_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] block_address;

    modport source (output valid, output status, output block_address, input ready);
    modport sink   (input valid, input status, input block_address, output ready);
endinterface

// ===== rtl/bma_ram.sv =====
module bma_ram #(
    parameter int AW = 10,
    parameter int W  = 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    // write one entry, register one read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/buddy_memory_allocator.sv =====
// Binary buddy allocator for one pool of 2^pool_order bytes at pool_base.
// Requests arrive as words on i_req (valid/ready): opcode 0 allocates
// request_bytes (plus header_bytes, rounded to a power of two), opcode 1
// frees an address returned earlier. Every request gives exactly one word
// on o_rsp carrying a status and, for a good allocate, the usable address.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write it only while idle, which the block does not enforce. Writing
// pool_order restarts the pool. An allocate passes through start, a scan and
// a check per node probed (at most 2^(pool_order-order+1)-1 nodes),
// take, a split state per split level, mark and respond; a zero-size or
// oversized allocate goes from start to respond. A free passes through two
// subtract states, a range check and a slot read, then a probe and, below
// the pool order, a buddy state, repeated per merge level (at most
// pool_order-MIN_ORDER), then set and respond; a rejected free ends early.
// The response word sits in an output register; i_req.ready rises as it is
// loaded and is high only when no request is in progress. Reset and every
// pool_order write clear all 2^(TOP_ORDER-MIN_ORDER+1)-1 tree nodes (2047 by
// default), taking no request meanwhile. A stalled receiver holds the word
// there; the block finishes the next request and waits to hand it over.
module buddy_memory_allocator #(
    parameter int TOP_ORDER = 15,
    parameter int MIN_ORDER = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    bma_req_if.sink     i_req,
    bma_rsp_if.source   o_rsp
);
    import bma_pkg::*;

    localparam int TW    = TOP_ORDER - MIN_ORDER + 1;
    localparam int SW    = TOP_ORDER - MIN_ORDER;
    localparam int OFW   = TOP_ORDER + 1;
    localparam logic [TW-1:0] LAST_NODE = TW'((2**TW) - 2);

    t_state r_state, n_state;
    logic [TW-1:0]  r_clr, n_clr;
    logic           r_op, n_op;
    logic [15:0]    r_req, n_req;
    logic [31:0]    r_addr, n_addr;
    logic [OFW-1:0] r_off, n_off;
    t_order         r_ord, n_ord;
    t_order         r_k, n_k;
    t_status        r_status, n_status;
    logic [31:0]    r_baddr, n_baddr;
    logic           r_o_valid, n_o_valid;
    t_status        r_o_status, n_o_status;
    logic [31:0]    r_o_baddr, n_o_baddr;
    logic [31:0]    r_pool_base, n_pool_base;
    logic [3:0]     r_pool_order, n_pool_order;
    logic [4:0]     r_hdr, n_hdr;

    logic           tree_we, tree_wd;
    logic [TW-1:0]  tree_wa, tree_ra;
    logic [0:0]     tree_rd;
    logic           used_we, used_wd;
    logic [SW-1:0]  slot_wa, slot_ra;
    logic [0:0]     used_rd;
    logic           ord_we;
    t_order         ord_rd;

    t_order         w_p, w_kq, w_split_o, w_ord_cl;
    logic [OFW-1:0] w_scan_nxt, w_buddy;
    logic           w_scan_wrap, w_oor, w_accept, w_cfg_pool;
    logic [32:0]    w_sub1, w_sub2;

    function automatic logic [OFW-1:0] pow2(input t_order o);
        return OFW'(1) << o;
    endfunction

    function automatic logic [TW-1:0] node_of(input t_order o, input logic [OFW-1:0] off);
        logic [OFW-1:0] b;
        b = (OFW'(1) << (5'(TOP_ORDER) - o)) - OFW'(1);
        return TW'(b + (off >> o));
    endfunction

    // clamp the pool order to the supported range
    always_comb begin
        w_p = {1'b0, r_pool_order};
        if (w_p < 5'(MIN_ORDER)) w_p = 5'(MIN_ORDER);
        if (w_p > 5'(TOP_ORDER)) w_p = 5'(TOP_ORDER);
    end

    // clamp the stored order of a freed block
    always_comb begin
        w_ord_cl = ord_rd;
        if (w_ord_cl < 5'(MIN_ORDER)) w_ord_cl = 5'(MIN_ORDER);
        if (w_ord_cl > w_p) w_ord_cl = w_p;
    end

    assign w_kq        = need_order(17'(r_req) + 17'(r_hdr), 5'(MIN_ORDER));
    assign w_split_o   = r_ord - 5'd1;
    assign w_scan_nxt  = r_off + pow2(r_ord);
    assign w_scan_wrap = w_scan_nxt >= pow2(w_p);
    assign w_buddy     = r_off ^ pow2(r_ord);
    assign w_sub1      = {1'b0, r_addr} - {1'b0, r_pool_base};
    assign w_sub2      = {1'b0, r_addr} - 33'(r_hdr);
    assign w_oor       = (r_addr >> w_p) != 32'd0;
    assign w_accept    = i_req.valid & i_req.ready;
    assign w_cfg_pool  = i_cfg_we && (i_cfg_idx == CFG_POOL_ORDER);

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.block_address = r_o_baddr;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_clr == LAST_NODE) n_state = S_IDLE;
            S_IDLE:    if (w_accept) n_state = (i_req.opcode == OP_ALLOC) ? S_A_START
                                                                         : S_F_SUB1;
            S_A_START: n_state = (r_req == 16'd0 || w_kq > w_p) ? S_RESP : S_A_SCAN;
            S_A_SCAN:  n_state = S_A_CHECK;
            S_A_CHECK: begin
                if (tree_rd[0]) n_state = S_A_TAKE;
                else if (w_scan_wrap && r_ord == w_p) n_state = S_RESP;
                else n_state = S_A_SCAN;
            end
            S_A_TAKE:  n_state = (r_ord > r_k) ? S_A_SPLIT : S_A_MARK;
            S_A_SPLIT: if (w_split_o == r_k) n_state = S_A_MARK;
            S_A_MARK:  n_state = S_RESP;
            S_F_SUB1:  n_state = (r_addr == 32'd0 || w_sub1[32]) ? S_RESP : S_F_SUB2;
            S_F_SUB2:  n_state = w_sub2[32] ? S_RESP : S_F_CHK;
            S_F_CHK:   n_state = (w_oor || r_addr[MIN_ORDER-1:0] != '0) ? S_RESP : S_F_SLOT;
            S_F_SLOT:  n_state = used_rd[0] ? S_F_PROBE : S_RESP;
            S_F_PROBE: n_state = (r_ord < w_p) ? S_F_BUDDY : S_F_SET;
            S_F_BUDDY: n_state = tree_rd[0] ? S_F_PROBE : S_F_SET;
            S_F_SET:   n_state = S_RESP;
            S_RESP:    if (!r_o_valid || o_rsp.ready) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
        if (w_cfg_pool) n_state = S_CLEAR;
    end

    // datapath and memory controls
    always_comb begin
        n_clr        = r_clr;
        n_op         = r_op;
        n_req        = r_req;
        n_addr       = r_addr;
        n_off        = r_off;
        n_ord        = r_ord;
        n_k          = r_k;
        n_status     = r_status;
        n_baddr      = r_baddr;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_baddr    = r_o_baddr;
        n_pool_base  = r_pool_base;
        n_pool_order = r_pool_order;
        n_hdr        = r_hdr;
        tree_we      = 1'b0;
        tree_wd      = 1'b0;
        tree_wa      = node_of(r_ord, r_off);
        tree_ra      = node_of(r_ord, (r_state == S_F_PROBE) ? w_buddy : r_off);
        used_we      = 1'b0;
        used_wd      = 1'b0;
        ord_we       = 1'b0;
        slot_wa      = r_off[TOP_ORDER-1:MIN_ORDER];
        slot_ra      = r_addr[TOP_ORDER-1:MIN_ORDER];

        // drop the output word once taken
        if (r_o_valid && o_rsp.ready) n_o_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                tree_we = 1'b1;
                tree_wa = r_clr;
                tree_wd = (r_clr == node_of(w_p, '0));
                used_we = 1'b1;
                slot_wa = r_clr[SW-1:0];
                n_clr   = r_clr + TW'(1);
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_req.opcode;
                    n_req    = i_req.request_bytes;
                    n_addr   = i_req.free_address;
                    n_status = ST_OK;
                    n_baddr  = 32'd0;
                end
            end
            S_A_START: begin
                if (r_req == 16'd0) n_status = ST_ZERO;
                else if (w_kq > w_p) n_status = ST_NOMEM;
                n_k   = w_kq;
                n_ord = w_kq;
                n_off = '0;
            end
            S_A_SCAN: ;
            S_A_CHECK: begin
                // advance to the next block, or up one order at the end of a level
                if (!tree_rd[0]) begin
                    if (w_scan_wrap) begin
                        if (r_ord == w_p) n_status = ST_NOMEM;
                        n_ord = r_ord + 5'd1;
                        n_off = '0;
                    end else begin
                        n_off = w_scan_nxt;
                    end
                end
            end
            S_A_TAKE: tree_we = 1'b1;
            S_A_SPLIT: begin
                // free the upper half one order down
                tree_we = 1'b1;
                tree_wd = 1'b1;
                tree_wa = node_of(w_split_o, r_off + pow2(w_split_o));
                n_ord   = w_split_o;
            end
            S_A_MARK: begin
                used_we = 1'b1;
                used_wd = 1'b1;
                ord_we  = 1'b1;
                n_baddr = r_pool_base + 32'(r_off) + 32'(r_hdr);
            end
            S_F_SUB1: begin
                if (r_addr != 32'd0 && w_sub1[32]) n_status = ST_RANGE;
                n_addr = w_sub1[31:0];
            end
            S_F_SUB2: begin
                if (w_sub2[32]) n_status = ST_RANGE;
                n_addr = w_sub2[31:0];
            end
            S_F_CHK: begin
                if (w_oor) n_status = ST_RANGE;
                n_off = OFW'(r_addr[TOP_ORDER-1:0]);
            end
            S_F_SLOT: begin
                if (used_rd[0]) begin
                    used_we = 1'b1;
                    n_ord   = w_ord_cl;
                end
            end
            S_F_PROBE: ;
            S_F_BUDDY: begin
                // merge with a free buddy
                if (tree_rd[0]) begin
                    tree_we = 1'b1;
                    tree_wa = node_of(r_ord, w_buddy);
                    n_off   = r_off & ~pow2(r_ord);
                    n_ord   = r_ord + 5'd1;
                end
            end
            S_F_SET: begin
                tree_we = 1'b1;
                tree_wd = 1'b1;
            end
            S_RESP: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_baddr  = r_baddr;
                end
            end
            default: ;
        endcase

        // take configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE:  n_pool_base  = i_cfg_data;
                CFG_POOL_ORDER: begin
                    n_pool_order = i_cfg_data[3:0];
                    n_clr        = '0;
                end
                CFG_HEADER:     n_hdr        = i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_o_valid    <= 1'b0;
            r_pool_base  <= 32'd0;
            r_pool_order <= 4'd15;
            r_hdr        <= 5'd20;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_o_valid    <= n_o_valid;
            r_pool_base  <= n_pool_base;
            r_pool_order <= n_pool_order;
            r_hdr        <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_off      <= n_off;
        r_ord      <= n_ord;
        r_k        <= n_k;
        r_status   <= n_status;
        r_baddr    <= n_baddr;
        r_o_status <= n_o_status;
        r_o_baddr  <= n_o_baddr;
    end

    bma_ram #(.AW(TW), .W(1)) u_tree (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_waddr (tree_wa),
        .i_wdata (tree_wd),
        .i_raddr (tree_ra),
        .o_rdata (tree_rd)
    );

    bma_ram #(.AW(SW), .W(1)) u_used (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (slot_wa),
        .i_wdata (used_wd),
        .i_raddr (slot_ra),
        .o_rdata (used_rd)
    );

    bma_ram #(.AW(SW), .W(5)) u_ord (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (slot_wa),
        .i_wdata (r_k),
        .i_raddr (slot_ra),
        .o_rdata (ord_rd)
    );

    // split only while above the requested order
    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_SPLIT) |-> (r_ord > r_k))
        else $error("split below requested order");

    // the marked block has exactly the requested order
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_MARK) |-> (r_ord == r_k && r_op == OP_ALLOC))
        else $error("marked block of wrong order");

    // only a good allocate carries an address
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_OK) |-> (r_o_baddr == 32'd0))
        else $error("address on failed request");
endmodule

// ===== test/buddy_memory_allocator_tb.sv =====
`timescale 1ns / 1ps

module buddy_memory_allocator_tb;
    import bma_pkg::*;

    localparam int MAXO  = 15;
    localparam int MINO  = 5;
    localparam int NODES = (1 << (MAXO - MINO + 1)) - 1;
    localparam int SLOTS = 1 << (MAXO - MINO);
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct packed {
        t_status     status;
        logic [31:0] block_address;
    } t_alloc_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    bma_req_if req_if ();
    bma_rsp_if rsp_if ();

    buddy_memory_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    // shadow copy of the allocator
    logic [31:0] pool_base;
    logic [3:0]  pool_order;
    logic [4:0]  header_bytes;
    bit          free_map [NODES];
    logic [3:0]  slot_ord [SLOTS];
    bit          slot_busy [SLOTS];

    t_alloc_rsp  pending_rsp[$];
    logic [31:0] live_blocks[$];
    logic [31:0] freed_blocks[$];

    int     send_idle_pct;
    int     rcv_idle_pct;
    int     mismatches;
    int     n_alloc, n_free, n_ok, n_nomem, n_range, n_zero;
    longint cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_rsp.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned node_idx(int unsigned ord, int unsigned off);
        int unsigned idx;
        idx = ((1 << (MAXO - ord)) - 1) + (off >> ord);
        return (idx < NODES) ? idx : 0;
    endfunction

    function automatic int unsigned live_order();
        int unsigned p;
        p = pool_order;
        if (p < MINO) p = MINO;
        if (p > MAXO) p = MAXO;
        return p;
    endfunction

    function automatic void restart_pool();
        foreach (free_map[i]) free_map[i] = 1'b0;
        foreach (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            slot_ord[i]  = 4'd0;
        end
        free_map[node_idx(live_order(), 0)] = 1'b1;
        live_blocks.delete();
        freed_blocks.delete();
    endfunction

    function automatic t_alloc_rsp take_block(logic [15:0] req_bytes);
        t_alloc_rsp  r;
        int unsigned p, need, k, o, off;
        bit          found;
        r = '{ST_OK, 32'd0};
        p = live_order();
        found = 1'b0;
        off = 0;
        if (req_bytes == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        need = req_bytes + header_bytes;
        k = MINO;
        while (k < 31 && (1 << k) < need) k++;
        if (k > p) begin
            r.status = ST_NOMEM;
            return r;
        end
        // lowest free block of the smallest order that fits
        for (o = k; o <= p; o++) begin
            for (int unsigned i = 0; i < (1 << (p - o)); i++) begin
                if (free_map[node_idx(o, i << o)]) begin
                    off = i << o;
                    found = 1'b1;
                    break;
                end
            end
            if (found) break;
        end
        if (!found) begin
            r.status = ST_NOMEM;
            return r;
        end
        // split down, releasing upper halves
        free_map[node_idx(o, off)] = 1'b0;
        while (o > k) begin
            o--;
            free_map[node_idx(o, off + (1 << o))] = 1'b1;
        end
        slot_busy[(off >> MINO) % SLOTS] = 1'b1;
        slot_ord[(off >> MINO) % SLOTS]  = 4'(k);
        r.block_address = pool_base + 32'(off) + 32'(header_bytes);
        return r;
    endfunction

    function automatic t_alloc_rsp give_back(logic [31:0] addr);
        t_alloc_rsp  r;
        int unsigned p, off, slot, o;
        logic [31:0] rel;
        r = '{ST_OK, 32'd0};
        p = live_order();
        if (addr == 0) return r;
        if (addr < pool_base) begin
            r.status = ST_RANGE;
            return r;
        end
        rel = addr - pool_base;
        if (rel < header_bytes) begin
            r.status = ST_RANGE;
            return r;
        end
        rel = rel - header_bytes;
        if (rel >= (33'd1 << p)) begin
            r.status = ST_RANGE;
            return r;
        end
        off = rel;
        // misaligned or not allocated: ignore
        if ((off & ((1 << MINO) - 1)) != 0) return r;
        slot = (off >> MINO) % SLOTS;
        if (!slot_busy[slot]) return r;
        slot_busy[slot] = 1'b0;
        o = slot_ord[slot];
        if (o < MINO) o = MINO;
        if (o > p) o = p;
        // merge with free buddies upward
        while (o < p) begin
            if (!free_map[node_idx(o, off ^ (1 << o))]) break;
            free_map[node_idx(o, off ^ (1 << o))] = 1'b0;
            off = off & ~(1 << o);
            o++;
        end
        free_map[node_idx(o, off)] = 1'b1;
        return r;
    endfunction

    // send one word, predict on acceptance
    task automatic send_req(logic op, logic [15:0] req_bytes, logic [31:0] addr);
        t_alloc_rsp r;
        int         gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.opcode        <= op;
        req_if.request_bytes <= req_bytes;
        req_if.free_address  <= addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (op == OP_ALLOC) begin
            n_alloc++;
            r = take_block(req_bytes);
            if (r.status == ST_OK) live_blocks.push_back(r.block_address);
        end else begin
            n_free++;
            r = give_back(addr);
        end
        pending_rsp.push_back(r);
    endtask

    // drop valid and wait for every outstanding word
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_POOL_BASE: pool_base = data;
            CFG_POOL_ORDER: begin
                pool_order = data[3:0];
                restart_pool();
            end
            CFG_HEADER: header_bytes = data[4:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic free_live(int unsigned pick);
        logic [31:0] a;
        a = live_blocks[pick];
        live_blocks.delete(pick);
        freed_blocks.push_back(a);
        if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
        send_req(OP_FREE, 16'd0, a);
    endtask

    // check each response word against the oldest prediction
    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d addr %h",
                             rsp_if.status, rsp_if.block_address);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.status != want.status
                        || rsp_if.block_address != want.block_address) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want status %0d addr %h, got %0d addr %h",
                                 want.status, want.block_address,
                                 rsp_if.status, rsp_if.block_address);
                end else begin
                    case (want.status)
                        ST_OK:    n_ok++;
                        ST_ZERO:  n_zero++;
                        ST_NOMEM: n_nomem++;
                        default:  n_range++;
                    endcase
                end
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic test_directed();
        logic [31:0] a0, a1;
        write_cfg(CFG_POOL_BASE, 32'h0);
        write_cfg(CFG_HEADER, 32'd20);
        write_cfg(CFG_POOL_ORDER, 32'd15);
        send_req(OP_ALLOC, 16'd0, 32'd0);
        send_req(OP_ALLOC, 16'd1, 32'd0);
        send_req(OP_ALLOC, 16'hFFFF, 32'd0);
        send_req(OP_ALLOC, 16'd16384, 32'd0);
        send_req(OP_ALLOC, 16'd12, 32'd0);
        send_req(OP_FREE, 16'd0, 32'd0);
        send_req(OP_FREE, 16'd0, 32'd5);
        send_req(OP_FREE, 16'd0, 32'hFFFF_FFFF);
        a0 = live_blocks[0];
        a1 = live_blocks[live_blocks.size() - 1];
        send_req(OP_FREE, 16'd0, a0 + 32'd1);
        send_req(OP_FREE, 16'd0, a0 + 32'd64);
        send_req(OP_FREE, 16'd0, a0);
        send_req(OP_FREE, 16'd0, a0);
        send_req(OP_FREE, 16'd0, a1);
        send_req(OP_ALLOC, 16'd32748, 32'd0);
        drain();
        // address wrap on the smallest pool with the largest header
        write_cfg(CFG_POOL_BASE, 32'hFFFF_FFF0);
        write_cfg(CFG_HEADER, 32'd31);
        write_cfg(CFG_POOL_ORDER, 32'd5);
        send_req(OP_ALLOC, 16'd1, 32'd0);
        send_req(OP_ALLOC, 16'd1, 32'd0);
        send_req(OP_ALLOC, 16'd2, 32'd0);
        send_req(OP_FREE, 16'd0, 32'h0000_000F);
        send_req(OP_FREE, 16'd0, 32'hFFFF_FFF0);
        drain();
        write_cfg(CFG_HEADER, 32'd0);
        send_req(OP_ALLOC, 16'd32, 32'd0);
        send_req(OP_FREE, 16'd0, 32'hFFFF_FFF0);
        send_req(OP_ALLOC, 16'd33, 32'd0);
        live_blocks.delete();
        drain();
    endtask

    // random traffic, mostly live allocs and frees, some noise
    task automatic test_random(int n_items, int ord, bit wide_base);
        int unsigned sel, size_top;
        logic [31:0] a;
        write_cfg(CFG_POOL_BASE, wide_base ? $urandom() : ($urandom() & 32'h00FF_FFE0));
        write_cfg(CFG_HEADER, $urandom_range(31));
        write_cfg(CFG_POOL_ORDER, ord);
        size_top = 1 << (ord - 2);
        repeat (n_items) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                send_req(OP_ALLOC, 16'($urandom_range(1, size_top)), 32'd0);
            end else if (sel < 50) begin
                send_req(OP_ALLOC, (sel < 47) ? 16'd0 : 16'($urandom()), 32'd0);
            end else if (sel < 85 && live_blocks.size() != 0) begin
                free_live($urandom_range(live_blocks.size() - 1));
            end else if (sel < 90 && freed_blocks.size() != 0) begin
                a = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
                send_req(OP_FREE, 16'd0, a + ($urandom_range(3) == 0 ? 32'd8 : 32'd0));
            end else if (sel < 93) begin
                send_req(OP_FREE, 16'd0, 32'd0);
            end else begin
                a = (sel < 96) ? pool_base + $urandom_range(0, (1 << ord) + 64) : $urandom();
                send_req(OP_FREE, 16'd0, a);
            end
        end
        // release some of what is left, stopping at random, so frees with merges dominate the tail
        while (live_blocks.size() != 0 && $urandom_range(1) == 1)
            free_live($urandom_range(live_blocks.size() - 1));
        drain();
    endtask

    initial begin
        cycles        = 0;
        mismatches    = 0;
        n_alloc = 0; n_free = 0; n_ok = 0; n_nomem = 0; n_range = 0; n_zero = 0;
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_POOL_BASE;
        i_cfg_data    = 32'd0;
        req_if.valid         = 1'b0;
        req_if.opcode        = OP_ALLOC;
        req_if.request_bytes = 16'd0;
        req_if.free_address  = 32'd0;
        rsp_if.ready         = 1'b0;
        pool_base    = 32'd0;
        pool_order   = 4'd15;
        header_bytes = 5'd20;
        restart_pool();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 77 : 0;
            rcv_idle_pct  = (mode == 0) ? 77 : (mode == 1) ? 36 : 0;
            test_random(80, 5, 1'b1);
            test_random(200, 8, 1'b0);
            test_random(200, 10, mode == 2);
        end
        test_random(100, 15, 1'b0);
        drain();

        $display("covered %0d allocates and %0d frees over pool orders 5 to 15",
                 n_alloc, n_free);
        $display("responses: %0d ok, %0d zero size, %0d no memory, %0d out of pool; %0d bad",
                 n_ok, n_zero, n_nomem, n_range, mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
